// ===== src/ptns_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptns_pkg
// shared types and constants of the point table nearest search block
// ----------------------------------------------------------------------------
package ptns_pkg;

  localparam int MAX_POINTS = 256;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int COORD_W    = 24;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int SQ_W       = 2 * COORD_W + 1;
  localparam int DIST_W     = SQ_W + 1;

  localparam logic [2:0] CMD_ADD     = 3'd0;
  localparam logic [2:0] CMD_SET     = 3'd1;
  localparam logic [2:0] CMD_DELETE  = 3'd2;
  localparam logic [2:0] CMD_NEAREST = 3'd3;
  localparam logic [2:0] CMD_CLEAR   = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [2:0]                cmd;
    logic [7:0]                entry_id;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                status;
    logic [7:0]                result_id;
    logic signed [COORD_W-1:0] result_x;
    logic signed [COORD_W-1:0] result_y;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_ADD,
    S_WALK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic decode;
    logic add;
    logic walk;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       has_id;
    logic       known;
    logic       empty;
    logic       del_hit;
    logic       walk_end;
    logic       out_free;
  } ctrl_sts_t;

endpackage

// ===== src/ptns_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptns_ctrl
// command sequencer: decode, add, list walk and result hand-off
// ----------------------------------------------------------------------------
module ptns_ctrl import ptns_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t ctl
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        case (sts.cmd)
          CMD_ADD:     state_nxt = sts.has_id ? S_ADD : S_DONE;
          CMD_DELETE:  state_nxt = sts.known ? S_WALK : S_DONE;
          CMD_NEAREST: state_nxt = sts.empty ? S_DONE : S_WALK;
          default:     state_nxt = S_DONE;
        endcase
      end
      S_ADD: begin
        state_nxt = S_DONE;
      end
      S_WALK: begin
        if (sts.del_hit || sts.walk_end) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall     = (state_r != S_IDLE);
    ctl          = '0;
    ctl.capture  = (state_r == S_IDLE) && in_valid;
    ctl.decode   = (state_r == S_DECODE);
    ctl.add      = (state_r == S_ADD);
    ctl.walk     = (state_r == S_WALK);
    ctl.load_out = (state_r == S_DONE) && sts.out_free;
  end

endmodule

// ===== src/ptns_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptns_dpath
// point memories, linked list registers, distance pipeline and output register
// ----------------------------------------------------------------------------
module ptns_dpath import ptns_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  ctrl_cmd_t ctl,
  output ctrl_sts_t sts,
  input  logic      out_stall,
  output logic      out_valid,
  output out_item_t out_data
);

  logic [IDX_W-1:0]          link_mem [MAX_POINTS];
  logic signed [COORD_W-1:0] px_mem   [MAX_POINTS];
  logic signed [COORD_W-1:0] py_mem   [MAX_POINTS];
  logic [IDX_W-1:0]          free_mem [MAX_POINTS];

  logic [IDX_W-1:0]          link_rd_r, free_rd_r;
  logic signed [COORD_W-1:0] px_rd_r, py_rd_r;

  in_item_t                  item_r;
  logic [MAX_POINTS-1:0]     valid_r, valid_nxt;
  logic [IDX_W-1:0]          head_r, head_nxt, tail_r, tail_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt, fresh_r, fresh_nxt, top_r, top_nxt;
  logic [CNT_W-1:0]          walk_cnt_r, walk_cnt_nxt;
  logic                      have_prev_r, have_prev_nxt;
  logic [IDX_W-1:0]          prev_r, prev_nxt;
  logic                      v_s1_r, v_s1_nxt, v_s2_r, v_s2_nxt;
  logic [IDX_W-1:0]          node_s1_r, node_s2_r;
  logic [SQ_W-1:0]           sqx_s2_r, sqy_s2_r;
  logic signed [COORD_W-1:0] x_s2_r, y_s2_r;
  logic                      best_v_r, best_v_nxt;
  logic [DIST_W-1:0]         best_d_r, best_d_nxt;
  logic [IDX_W-1:0]          best_id_r, best_id_nxt;
  logic signed [COORD_W-1:0] best_x_r, best_x_nxt, best_y_r, best_y_nxt;
  out_item_t                 res_r, res_nxt;
  logic                      out_valid_r;
  out_item_t                 out_data_r;

  logic                      link_we, pt_we, free_we;
  logic [IDX_W-1:0]          link_wa, link_wd, pt_wa, free_ra, walk_addr, nid;
  logic                      known, has_id, issue, del_hit, walk_end, is_del;
  logic signed [DIFF_W-1:0]  dx, dy;
  logic signed [2*DIFF_W-1:0] prod_x, prod_y;
  logic [DIST_W-1:0]         sum_sq;

  always_comb begin
    known     = valid_r[item_r.entry_id];
    has_id    = (top_r != '0) || (fresh_r < CNT_W'(MAX_POINTS));
    nid       = (top_r != '0) ? free_rd_r : fresh_r[IDX_W-1:0];
    free_ra   = top_r[IDX_W-1:0] - 1'b1;
    issue     = ctl.walk && (walk_cnt_r < count_r);
    walk_addr = (walk_cnt_r == '0) ? head_r : link_rd_r;
    is_del    = (item_r.cmd == CMD_DELETE);
    del_hit   = ctl.walk && is_del && v_s1_r && (node_s1_r == item_r.entry_id);
    walk_end  = (walk_cnt_r == count_r) && !v_s1_r && !v_s2_r;
    dx        = $signed({px_rd_r[COORD_W-1], px_rd_r})
              - $signed({item_r.coord_x[COORD_W-1], item_r.coord_x});
    dy        = $signed({py_rd_r[COORD_W-1], py_rd_r})
              - $signed({item_r.coord_y[COORD_W-1], item_r.coord_y});
    prod_x    = dx * dx;
    prod_y    = dy * dy;
    sum_sq    = {1'b0, sqx_s2_r} + {1'b0, sqy_s2_r};
  end

  always_comb begin
    valid_nxt     = valid_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    fresh_nxt     = fresh_r;
    top_nxt       = top_r;
    walk_cnt_nxt  = walk_cnt_r;
    have_prev_nxt = have_prev_r;
    prev_nxt      = prev_r;
    v_s1_nxt      = 1'b0;
    v_s2_nxt      = 1'b0;
    best_v_nxt    = best_v_r;
    best_d_nxt    = best_d_r;
    best_id_nxt   = best_id_r;
    best_x_nxt    = best_x_r;
    best_y_nxt    = best_y_r;
    res_nxt       = res_r;
    link_we       = 1'b0;
    link_wa       = tail_r;
    link_wd       = nid;
    pt_we         = 1'b0;
    pt_wa         = item_r.entry_id;
    free_we       = 1'b0;

    if (ctl.decode) begin
      walk_cnt_nxt  = '0;
      have_prev_nxt = 1'b0;
      best_v_nxt    = 1'b0;
      res_nxt       = '0;
      case (item_r.cmd)
        CMD_ADD: begin
          if (!has_id) res_nxt.status = ST_FULL;
        end
        CMD_SET: begin
          if (known) begin
            pt_we          = 1'b1;
            res_nxt.status = ST_OK;
          end else begin
            res_nxt.status = ST_MISS;
          end
        end
        CMD_DELETE: begin
          if (!known) res_nxt.status = ST_MISS;
        end
        CMD_NEAREST: begin
          if (count_r == '0) res_nxt.status = ST_MISS;
        end
        CMD_CLEAR: begin
          valid_nxt      = '0;
          head_nxt       = '0;
          tail_nxt       = '0;
          count_nxt      = '0;
          fresh_nxt      = '0;
          top_nxt        = '0;
          res_nxt.status = ST_OK;
        end
        default: begin
          res_nxt.status = ST_MISS;
        end
      endcase
    end

    if (ctl.add) begin
      pt_we          = 1'b1;
      pt_wa          = nid;
      valid_nxt[nid] = 1'b1;
      if (count_r != '0) begin
        link_we = 1'b1;
      end else begin
        head_nxt = nid;
      end
      tail_nxt  = nid;
      count_nxt = count_r + 1'b1;
      if (top_r != '0) begin
        top_nxt = top_r - 1'b1;
      end else begin
        fresh_nxt = fresh_r + 1'b1;
      end
      res_nxt           = '0;
      res_nxt.status    = ST_OK;
      res_nxt.result_id = nid;
    end

    if (ctl.walk) begin
      if (issue) walk_cnt_nxt = walk_cnt_r + 1'b1;
      v_s1_nxt = issue;
      v_s2_nxt = v_s1_r && !is_del;
      if (v_s1_r && is_del && !del_hit) begin
        have_prev_nxt = 1'b1;
        prev_nxt      = node_s1_r;
      end
      if (v_s2_r && (!best_v_r || (sum_sq < best_d_r))) begin
        best_v_nxt  = 1'b1;
        best_d_nxt  = sum_sq;
        best_id_nxt = node_s2_r;
        best_x_nxt  = x_s2_r;
        best_y_nxt  = y_s2_r;
      end
      if (del_hit) begin
        if (!have_prev_r) begin
          head_nxt = link_rd_r;
        end else begin
          link_we = 1'b1;
          link_wa = prev_r;
          link_wd = link_rd_r;
        end
        if (tail_r == item_r.entry_id) tail_nxt = have_prev_r ? prev_r : '0;
        valid_nxt[item_r.entry_id] = 1'b0;
        count_nxt = count_r - 1'b1;
        if (count_r == CNT_W'(1)) begin
          head_nxt = '0;
          tail_nxt = '0;
        end
        if (top_r < CNT_W'(MAX_POINTS)) begin
          free_we = 1'b1;
          top_nxt = top_r + 1'b1;
        end
        res_nxt        = '0;
        res_nxt.status = ST_OK;
      end else if (walk_end) begin
        res_nxt = '0;
        if (is_del) begin
          res_nxt.status = ST_MISS;
        end else begin
          res_nxt.status    = ST_OK;
          res_nxt.result_id = best_id_r;
          res_nxt.result_x  = best_x_r;
          res_nxt.result_y  = best_y_r;
        end
      end
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    if (pt_we) begin
      px_mem[pt_wa] <= item_r.coord_x;
      py_mem[pt_wa] <= item_r.coord_y;
    end
    if (free_we) free_mem[top_r[IDX_W-1:0]] <= item_r.entry_id;
    link_rd_r <= link_mem[walk_addr];
    px_rd_r   <= px_mem[walk_addr];
    py_rd_r   <= py_mem[walk_addr];
    free_rd_r <= free_mem[free_ra];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.capture) item_r <= in_data;
    node_s1_r <= walk_addr;
    node_s2_r <= node_s1_r;
    sqx_s2_r  <= prod_x[SQ_W-1:0];
    sqy_s2_r  <= prod_y[SQ_W-1:0];
    x_s2_r    <= px_rd_r;
    y_s2_r    <= py_rd_r;
    prev_r    <= prev_nxt;
    best_d_r  <= best_d_nxt;
    best_id_r <= best_id_nxt;
    best_x_r  <= best_x_nxt;
    best_y_r  <= best_y_nxt;
    res_r     <= res_nxt;
    if (ctl.load_out) out_data_r <= res_r;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      fresh_r     <= '0;
      top_r       <= '0;
      walk_cnt_r  <= '0;
      have_prev_r <= 1'b0;
      v_s1_r      <= 1'b0;
      v_s2_r      <= 1'b0;
      best_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      fresh_r     <= fresh_nxt;
      top_r       <= top_nxt;
      walk_cnt_r  <= walk_cnt_nxt;
      have_prev_r <= have_prev_nxt;
      v_s1_r      <= v_s1_nxt;
      v_s2_r      <= v_s2_nxt;
      best_v_r    <= best_v_nxt;
      if (ctl.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    sts          = '0;
    sts.cmd      = item_r.cmd;
    sts.has_id   = has_id;
    sts.known    = known;
    sts.empty    = (count_r == '0);
    sts.del_hit  = del_hit;
    sts.walk_end = walk_end;
    sts.out_free = !out_valid_r || !out_stall;
    out_valid    = out_valid_r;
    out_data     = out_data_r;
  end

endmodule

// ===== src/point_table_nearest_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_table_nearest_search
// table of 2-d points in a linked list with add, set, delete, nearest, clear
// ----------------------------------------------------------------------------
//  channel | ports                        | transaction
//  in      | in_valid, in_stall, in_data  | one command
//  out     | out_valid, out_stall, out_data | one result per command
//
//  one command at a time; add, set, clear and bad codes need no list walk;
//  delete and nearest walk the list one entry per cycle on the next-link
//  memory read port, delete until it finds the entry, nearest to the end
//  reset clears the list registers and valid bits at once, no memory sweep
//  a stalled result holds in the output register until taken
// ----------------------------------------------------------------------------
module point_table_nearest_search import ptns_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  ctrl_cmd_t ctl;
  ctrl_sts_t sts;

  ptns_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  ptns_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .ctl       (ctl),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== tb/point_table_nearest_search_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_table_nearest_search_tb
// drives add, set, delete, nearest, clear and unused command codes into the
// point table, predicts every result from a model of the linked table kept
// in a scoreboard, and compares each result transaction field by field
// ----------------------------------------------------------------------------
module point_table_nearest_search_tb;
  import ptns_pkg::*;

  localparam int NUM_ITEMS  = 1500;
  localparam int HOLD_LEN   = 3000;
  localparam int CYCLE_CAP  = 3000000;
  localparam int DRAIN_WAIT = 300;

  class point_book;
    bit                        live [MAX_POINTS];
    logic signed [COORD_W-1:0] px [MAX_POINTS];
    logic signed [COORD_W-1:0] py [MAX_POINTS];
    int                        link [MAX_POINTS];
    int                        freed [MAX_POINTS];
    int                        head, tail, count, fresh, freed_top;
    out_item_t                 want_q [$];
    int                        errors;

    function new();
      errors = 0;
      wipe();
    endfunction

    function void wipe();
      for (int i = 0; i < MAX_POINTS; i++) begin
        live[i] = 0;
        px[i] = '0;
        py[i] = '0;
        link[i] = 0;
        freed[i] = 0;
      end
      head = 0;
      tail = 0;
      count = 0;
      fresh = 0;
      freed_top = 0;
    endfunction

    function longint sq_dist(logic signed [COORD_W-1:0] ax, logic signed [COORD_W-1:0] ay,
                             logic signed [COORD_W-1:0] bx, logic signed [COORD_W-1:0] by);
      longint dx, dy;
      dx = longint'(ax) - longint'(bx);
      dy = longint'(ay) - longint'(by);
      return dx * dx + dy * dy;
    endfunction

    function out_item_t predict(in_item_t it);
      out_item_t r;
      int nid, node, prev, best_id;
      bit have_prev;
      longint d, best;
      r = '0;
      case (it.cmd)
        CMD_ADD: begin
          if (freed_top > 0) begin
            freed_top--;
            nid = freed[freed_top];
          end else if (fresh < MAX_POINTS) begin
            nid = fresh;
            fresh++;
          end else begin
            r.status = ST_FULL;
            return r;
          end
          live[nid] = 1;
          px[nid] = it.coord_x;
          py[nid] = it.coord_y;
          link[nid] = 0;
          if (count == 0) head = nid;
          else link[tail] = nid;
          tail = nid;
          count++;
          r.status = ST_OK;
          r.result_id = nid[7:0];
        end
        CMD_SET: begin
          if (!live[it.entry_id]) begin
            r.status = ST_MISS;
          end else begin
            px[it.entry_id] = it.coord_x;
            py[it.entry_id] = it.coord_y;
            r.status = ST_OK;
          end
        end
        CMD_DELETE: begin
          if (!live[it.entry_id]) begin
            r.status = ST_MISS;
            return r;
          end
          node = head;
          prev = 0;
          have_prev = 0;
          for (int i = 0; i < count && node != it.entry_id; i++) begin
            prev = node;
            have_prev = 1;
            node = link[node];
          end
          if (node != it.entry_id) begin
            r.status = ST_MISS;
            return r;
          end
          if (!have_prev) head = link[node];
          else link[prev] = link[node];
          if (tail == node) tail = have_prev ? prev : 0;
          live[node] = 0;
          count--;
          if (count == 0) begin
            head = 0;
            tail = 0;
          end
          if (freed_top < MAX_POINTS) begin
            freed[freed_top] = node;
            freed_top++;
          end
          r.status = ST_OK;
        end
        CMD_NEAREST: begin
          if (count == 0) begin
            r.status = ST_MISS;
            return r;
          end
          node = head;
          best_id = 0;
          best = 0;
          for (int i = 0; i < count; i++) begin
            d = sq_dist(px[node], py[node], it.coord_x, it.coord_y);
            if (i == 0 || d < best) begin
              best = d;
              best_id = node;
            end
            node = link[node];
          end
          r.status = ST_OK;
          r.result_id = best_id[7:0];
          r.result_x = px[best_id];
          r.result_y = py[best_id];
        end
        CMD_CLEAR: begin
          wipe();
          r.status = ST_OK;
        end
        default: r.status = ST_MISS;
      endcase
      return r;
    endfunction

    function void note_command(in_item_t it);
      want_q.push_back(predict(it));
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (want_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transaction %p", got);
        return;
      end
      want = want_q.pop_front();
      if (got.status !== want.status || got.result_id !== want.result_id ||
          got.result_x !== want.result_x || got.result_y !== want.result_y) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected st %0d id %0d x %0d y %0d, got st %0d id %0d x %0d y %0d",
                   want.status, want.result_id, want.result_x, want.result_y,
                   got.status, got.result_id, got.result_x, got.result_y);
      end
    endfunction

    function int pending();
      return want_q.size();
    endfunction

    function int pick_live();
      int node, steps;
      if (count == 0) return $urandom_range(0, 255);
      node = head;
      steps = $urandom_range(0, count - 1);
      for (int i = 0; i < steps; i++) node = link[node];
      return node;
    endfunction

    function logic signed [COORD_W-1:0] some_coord(int axis);
      int sel, n;
      logic signed [COORD_W-1:0] c;
      sel = $urandom_range(0, 9);
      case (sel)
        0: c = $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
        1, 2: c = $signed(24'($urandom_range(0, 64))) - 24'sd32;
        3: begin
          if (count > 0) begin
            n = pick_live();
            c = axis ? py[n] : px[n];
          end else begin
            c = '0;
          end
        end
        default: c = 24'($urandom());
      endcase
      return c;
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  point_book book;
  bit        hold_req;
  int        burst_left;
  int        sent;
  longint    cycles;

  point_table_nearest_search dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_CAP) begin
        $display("point_table_nearest_search test failed");
        $finish;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) book.check_result(out_data);
  end

  // receiver stall pattern with an occasional long hold
  initial begin
    int span, mode;
    out_stall = 0;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        out_stall <= 1;
        repeat (HOLD_LEN) @(posedge clk);
        hold_req = 0;
      end else begin
        span = $urandom_range(1, 40);
        mode = $urandom_range(0, 3);
        repeat (span) begin
          case (mode)
            0: out_stall <= 0;
            1: out_stall <= ($urandom_range(0, 9) < 3);
            2: out_stall <= ($urandom_range(0, 9) < 8);
            default: out_stall <= ($urandom_range(0, 1) == 1);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  task automatic send_cmd(input in_item_t it);
    if (burst_left == 0) begin
      int gap;
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 0;
        in_data.coord_x <= 24'($urandom());
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    book.note_command(it);
    sent++;
  endtask

  task automatic send_fields(input logic [2:0] cmd, input int id,
                             input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y);
    in_item_t it;
    it.cmd = cmd;
    it.entry_id = id[7:0];
    it.coord_x = x;
    it.coord_y = y;
    send_cmd(it);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (book.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_cmd(input int add_pct);
    int roll;
    logic [2:0] cmd;
    int id;
    roll = $urandom_range(0, 99);
    if (roll < add_pct) cmd = CMD_ADD;
    else if (roll < add_pct + 15) cmd = CMD_SET;
    else if (roll < add_pct + 35) cmd = CMD_DELETE;
    else if (roll < 96) cmd = CMD_NEAREST;
    else if (roll < 97) cmd = CMD_CLEAR;
    else cmd = 3'($urandom_range(5, 7));
    if ((cmd == CMD_SET || cmd == CMD_DELETE) && $urandom_range(0, 9) < 8)
      id = book.pick_live();
    else
      id = $urandom_range(0, 255);
    send_fields(cmd, id, book.some_coord(0), book.some_coord(1));
  endtask

  initial begin
    book = new();
    hold_req = 0;
    burst_left = 0;
    sent = 0;
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed corner cases
    send_fields(CMD_NEAREST, 0, 0, 0);
    send_fields(CMD_SET, 0, 5, 5);
    send_fields(CMD_DELETE, 255, 0, 0);
    send_fields(3'd5, 17, 24'sh7fffff, 24'sh800000);
    send_fields(3'd6, 255, 24'sh7fffff, 24'sh7fffff);
    send_fields(3'd7, 128, 24'sh800000, 24'sh800000);
    send_fields(CMD_ADD, 0, 24'sh7fffff, 24'sh7fffff);
    send_fields(CMD_ADD, 0, 24'sh800000, 24'sh800000);
    send_fields(CMD_ADD, 0, 0, 0);
    send_fields(CMD_ADD, 0, 0, 0);
    send_fields(CMD_NEAREST, 0, 0, 0);
    send_fields(CMD_NEAREST, 0, 24'sh800000, 24'sh7fffff);
    send_fields(CMD_NEAREST, 0, 24'sh7fffff, 24'sh800000);
    send_fields(CMD_SET, 1, 24'sh7fffff, 24'sh7fffff);
    send_fields(CMD_NEAREST, 0, 24'sh7fffff, 24'sh7fffff);
    send_fields(CMD_DELETE, 0, 0, 0);
    send_fields(CMD_DELETE, 3, 0, 0);
    send_fields(CMD_DELETE, 0, 0, 0);
    send_fields(CMD_ADD, 0, 24'sh000100, 24'shffff00);
    send_fields(CMD_ADD, 0, 24'sh123456, 24'sh654321);
    send_fields(CMD_NEAREST, 0, 1, 1);
    send_fields(CMD_CLEAR, 0, 0, 0);
    send_fields(CMD_NEAREST, 0, 0, 0);
    drain();

    // receiver holds off while commands keep coming
    hold_req = 1;
    repeat (20) random_cmd(50);
    drain();

    // fill the table to full, then probe it
    send_fields(CMD_CLEAR, 0, 0, 0);
    repeat (MAX_POINTS + 3) send_fields(CMD_ADD, 0, book.some_coord(0), book.some_coord(1));
    repeat (30) random_cmd(30);
    drain();

    while (sent < NUM_ITEMS) begin
      int phase_len, add_pct;
      phase_len = $urandom_range(20, 120);
      add_pct = $urandom_range(20, 60);
      repeat (phase_len) random_cmd(add_pct);
      if ($urandom_range(0, 3) == 0) drain();
    end
    drain();

    repeat (DRAIN_WAIT) @(posedge clk);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("point_table_nearest_search test passed");
    end else begin
      $display("point_table_nearest_search test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/ptns_pkg.sv
src/ptns_ctrl.sv
src/ptns_dpath.sv
src/point_table_nearest_search.sv
tb/point_table_nearest_search_tb.sv
